/* src/assert_macros.svh */
// concurrent assertion helpers, empty when synthesising
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// consequent checked in the same cycle
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* src/cnre_pkg.sv */
package cnre_pkg;

    localparam int unsigned MaxNodes = 16;
    localparam logic [31:0] BaseValue = 32'd42;
    localparam int unsigned MaxItems = 4;
    localparam logic [31:0] FailedAck = 32'hFFFF_FFFF;

    localparam logic [3:0]  NodeIdRst = 4'd0;
    localparam logic [4:0]  NodeCountRst = 5'd3;
    localparam logic [15:0] TimeoutRst = 16'd32;
    localparam logic [7:0]  LimitRst = 8'd10;

    localparam logic [1:0] CfgNodeId = 2'd0;
    localparam logic [1:0] CfgNodeCount = 2'd1;
    localparam logic [1:0] CfgTimeout = 2'd2;
    localparam logic [1:0] CfgLimit = 2'd3;

    localparam logic [1:0] RoleCodeLeader = 2'd0;
    localparam logic [1:0] RoleCodeFollower = 2'd1;
    localparam logic [1:0] RoleCodeCandidate = 2'd2;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_VOTE_REQ  = 3'd1,
        CMD_HEARTBEAT = 3'd2,
        CMD_VOTE_RESP = 3'd3,
        CMD_PROPOSAL  = 3'd4,
        CMD_ACK       = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        KIND_STATUS     = 4'd0,
        KIND_VOTE_REQ   = 4'd1,
        KIND_VOTE_RESP  = 4'd2,
        KIND_HEARTBEAT  = 4'd3,
        KIND_PROPOSAL   = 4'd4,
        KIND_ACK        = 4'd5,
        KIND_COMMIT     = 4'd6,
        KIND_NO_QUORUM  = 4'd7,
        KIND_WON        = 4'd8,
        KIND_FAILED_ACK = 4'd9
    } t_kind;

    typedef enum logic [2:0] {
        ROLE_LEADER    = 3'b001,
        ROLE_FOLLOWER  = 3'b010,
        ROLE_CANDIDATE = 3'b100
    } t_role;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] msg_term;
        logic [3:0]  sender;
        logic        fault;
        logic [31:0] value_in;
        logic [7:0]  proposal_number;
        logic [7:0]  decision_number;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  dest;
        logic        bcast;
        logic [31:0] term;
        logic [31:0] value;
        logic [7:0]  props;
        logic [7:0]  decs;
    } t_item;

    typedef struct packed {
        t_role       role;
        logic [31:0] term;
        logic [4:0]  votes;
        logic [4:0]  resp;
        logic        open;
        logic [4:0]  acks;
        logic [4:0]  seen;
        logic [7:0]  props;
        logic [7:0]  decs;
        logic [31:0] pend;
        logic [15:0] ticks;
    } t_state;

endpackage

/* src/cnre_in_if.sv */
interface cnre_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] msg_term;
    logic [3:0]  sender;
    logic        fault;
    logic [31:0] value_in;
    logic [7:0]  proposal_number;
    logic [7:0]  decision_number;

    modport source (
        output valid, cmd, msg_term, sender, fault, value_in, proposal_number,
               decision_number,
        input  ready
    );

    modport sink (
        input  valid, cmd, msg_term, sender, fault, value_in, proposal_number,
               decision_number,
        output ready
    );
endinterface

/* src/cnre_out_if.sv */
interface cnre_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [3:0]  dest;
    logic        broadcast;
    logic [31:0] out_term;
    logic [31:0] out_value;
    logic [7:0]  out_proposals;
    logic [1:0]  role;
    logic [7:0]  decisions;
    logic        done_res;
    logic        last;

    modport source (
        output valid, kind, dest, broadcast, out_term, out_value, out_proposals,
               role, decisions, done_res, last,
        input  ready
    );

    modport sink (
        input  valid, kind, dest, broadcast, out_term, out_value, out_proposals,
               role, decisions, done_res, last,
        output ready
    );
endinterface

/* src/consensus_node_role_engine.sv */
// the input transaction goes to the input register, then to the result bank that drives the output
// each event gives one to four result transactions, sent one per cycle while the receiver is ready
// through the single result port; a new event waits in the input register until the bank has sent
// the last result of the one before; events with one result run one per cycle while the receiver is ready
// reset (synchronous, active low): configuration, state and handshake registers at defaults, node 0 as leader
`include "assert_macros.svh"

module consensus_node_role_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cnre_in_if.sink            i_in,
    cnre_out_if.source         o_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    localparam logic [6:0] MaxNodesW = 7'(cnre_pkg::MaxNodes);

    function automatic logic [4:0] inc5(input logic [4:0] v);
        return (v < 5'd31) ? v + 5'd1 : 5'd31;
    endfunction

    function automatic logic [7:0] inc8(input logic [7:0] v);
        return (v < 8'd255) ? v + 8'd1 : 8'd255;
    endfunction

    function automatic cnre_pkg::t_item mk_item(
        input cnre_pkg::t_kind kind,
        input logic [3:0]      dest,
        input logic            bcast,
        input logic [31:0]     term,
        input logic [31:0]     value,
        input logic [7:0]      props,
        input logic [7:0]      decs
    );
        cnre_pkg::t_item it;
        it.kind  = kind;
        it.dest  = dest;
        it.bcast = bcast;
        it.term  = term;
        it.value = value;
        it.props = props;
        it.decs  = decs;
        return it;
    endfunction

    function automatic logic [1:0] role_code(input cnre_pkg::t_role r);
        logic [1:0] c;
        case (r)
            cnre_pkg::ROLE_LEADER:    c = cnre_pkg::RoleCodeLeader;
            cnre_pkg::ROLE_FOLLOWER:  c = cnre_pkg::RoleCodeFollower;
            cnre_pkg::ROLE_CANDIDATE: c = cnre_pkg::RoleCodeCandidate;
            default:                  c = cnre_pkg::RoleCodeLeader;
        endcase
        return c;
    endfunction

    // configuration
    logic [3:0]  r_node_id;
    logic [4:0]  r_node_count;
    logic [15:0] r_timeout;
    logic [7:0]  r_limit;

    // input register
    logic               r_in_vld;
    cnre_pkg::t_in_item r_in;

    // node state
    cnre_pkg::t_state r_st;
    cnre_pkg::t_state n_st;

    // result bank
    logic            r_out_vld;
    cnre_pkg::t_item r_items [cnre_pkg::MaxItems];
    logic [1:0]      r_idx;
    logic [1:0]      r_last;
    logic [1:0]      r_role_o;
    logic            r_done_o;

    cnre_pkg::t_item n_items [cnre_pkg::MaxItems];
    logic [1:0]      n_last;
    logic            n_done;

    logic in_acc;
    logic out_take;
    logic bank_free;
    logic load;

    assign out_take  = r_out_vld && o_out.ready;
    assign bank_free = !r_out_vld || (o_out.ready && (r_idx == r_last));
    assign load      = r_in_vld && bank_free;
    assign i_in.ready = !r_in_vld || bank_free;
    assign in_acc    = i_in.valid && i_in.ready;

    always_comb begin : p_event
        cnre_pkg::t_state s;
        logic [2:0]  n;
        logic [4:0]  gs;
        logic [4:0]  half;
        logic [15:0] t;
        logic        do_quorum;
        logic        do_close;
        logic        do_beat;
        logic        lead_fault;

        s = r_st;
        n = '0;
        t = '0;
        do_quorum  = 1'b0;
        do_close   = 1'b0;
        do_beat    = 1'b0;
        lead_fault = 1'b0;
        for (int k = 0; k < cnre_pkg::MaxItems; k++) begin
            n_items[k] = '0;
        end
        gs   = ({2'b00, r_node_count} > MaxNodesW) ? MaxNodesW[4:0] : r_node_count;
        half = gs >> 1;

        if (r_st.decs < r_limit) begin
            case (r_in.cmd)
                cnre_pkg::CMD_TICK: begin
                    if (s.role == cnre_pkg::ROLE_LEADER) begin
                        if (!s.open) begin
                            s.pend  = cnre_pkg::BaseValue + 32'(s.props);
                            s.props = inc8(s.props);
                            s.open  = 1'b1;
                            s.acks  = 5'd1;
                            s.seen  = 5'd1;
                            n_items[n[1:0]] = mk_item(cnre_pkg::KIND_PROPOSAL, r_node_id,
                                1'b1, s.term, s.pend, s.props, s.decs);
                            n = n + 3'd1;
                        end
                        do_quorum  = 1'b1;
                        lead_fault = r_in.fault;
                        do_beat    = !r_in.fault;
                    end else begin
                        t = (s.ticks != 16'd0) ? s.ticks - 16'd1 : 16'd0;
                        s.ticks = t;
                        if (t == 16'd0) begin
                            s.role  = cnre_pkg::ROLE_CANDIDATE;
                            s.term  = s.term + 32'd1;
                            s.votes = 5'd1;
                            s.resp  = 5'd1;
                            s.ticks = r_timeout;
                            n_items[n[1:0]] = mk_item(cnre_pkg::KIND_VOTE_REQ, r_node_id,
                                1'b1, s.term, '0, '0, s.decs);
                            n = n + 3'd1;
                            do_close = 1'b1;
                        end
                    end
                end
                cnre_pkg::CMD_VOTE_REQ: begin
                    n_items[n[1:0]] = mk_item(cnre_pkg::KIND_VOTE_RESP, r_in.sender,
                        1'b0, s.term, '0, '0, s.decs);
                    n = n + 3'd1;
                    if (r_in.msg_term > s.term) begin
                        s.role  = cnre_pkg::ROLE_FOLLOWER;
                        s.term  = r_in.msg_term;
                        s.ticks = r_timeout;
                    end
                end
                cnre_pkg::CMD_HEARTBEAT: begin
                    if (r_in.msg_term >= s.term) begin
                        s.role  = cnre_pkg::ROLE_FOLLOWER;
                        s.term  = r_in.msg_term;
                        s.ticks = r_timeout;
                    end
                end
                cnre_pkg::CMD_VOTE_RESP: begin
                    if (s.role == cnre_pkg::ROLE_CANDIDATE) begin
                        if (r_in.msg_term < s.term) begin
                            s.votes = inc5(s.votes);
                        end else if (r_in.msg_term > s.term) begin
                            s.role  = cnre_pkg::ROLE_FOLLOWER;
                            s.term  = r_in.msg_term;
                            s.ticks = r_timeout;
                        end
                        s.resp   = inc5(s.resp);
                        do_close = 1'b1;
                    end
                end
                cnre_pkg::CMD_PROPOSAL: begin
                    if (s.role == cnre_pkg::ROLE_FOLLOWER) begin
                        if (r_in.fault) begin
                            n_items[n[1:0]] = mk_item(cnre_pkg::KIND_FAILED_ACK,
                                r_in.sender, 1'b0, s.term, cnre_pkg::FailedAck, '0, s.decs);
                        end else begin
                            n_items[n[1:0]] = mk_item(cnre_pkg::KIND_ACK,
                                r_in.sender, 1'b0, s.term, r_in.value_in, '0, s.decs);
                        end
                        n = n + 3'd1;
                        s.props = r_in.proposal_number;
                        s.decs  = r_in.decision_number;
                    end
                end
                cnre_pkg::CMD_ACK: begin
                    if (s.role == cnre_pkg::ROLE_LEADER && s.open) begin
                        if (r_in.fault) begin
                            s.seen    = inc5(s.seen);
                            do_quorum = 1'b1;
                        end else if (r_in.value_in == s.pend) begin
                            s.acks    = inc5(s.acks);
                            s.seen    = inc5(s.seen);
                            do_quorum = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (do_quorum && s.open) begin
                if (s.acks > half) begin
                    s.decs = inc8(s.decs);
                    s.open = 1'b0;
                    n_items[n[1:0]] = mk_item(cnre_pkg::KIND_COMMIT, r_node_id, 1'b0,
                        s.term, s.pend, '0, s.decs);
                    n = n + 3'd1;
                end else if (s.seen >= gs) begin
                    s.open = 1'b0;
                    n_items[n[1:0]] = mk_item(cnre_pkg::KIND_NO_QUORUM, r_node_id, 1'b0,
                        s.term, s.pend, '0, s.decs);
                    n = n + 3'd1;
                end
            end

            if (lead_fault) begin
                s.role  = cnre_pkg::ROLE_FOLLOWER;
                s.ticks = r_timeout;
            end else if (do_beat) begin
                n_items[n[1:0]] = mk_item(cnre_pkg::KIND_HEARTBEAT, r_node_id, 1'b1,
                    s.term, '0, '0, s.decs);
                n = n + 3'd1;
            end

            if (do_close && s.role == cnre_pkg::ROLE_CANDIDATE && s.resp >= gs) begin
                if (s.votes > half) begin
                    s.role = cnre_pkg::ROLE_LEADER;
                    n_items[n[1:0]] = mk_item(cnre_pkg::KIND_WON, r_node_id, 1'b0,
                        s.term, '0, '0, s.decs);
                    n = n + 3'd1;
                end else begin
                    s.role = cnre_pkg::ROLE_FOLLOWER;
                end
                s.ticks = r_timeout;
            end

            if (s.role == cnre_pkg::ROLE_FOLLOWER) begin
                s.open = 1'b0;
                s.acks = '0;
                s.seen = '0;
            end
        end

        n_items[n[1:0]] = mk_item(cnre_pkg::KIND_STATUS, r_node_id, 1'b0, s.term,
            s.pend, s.props, s.decs);
        n_last = n[1:0];
        n_done = (s.decs >= r_limit);
        n_st   = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id    <= cnre_pkg::NodeIdRst;
            r_node_count <= cnre_pkg::NodeCountRst;
            r_timeout    <= cnre_pkg::TimeoutRst;
            r_limit      <= cnre_pkg::LimitRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cnre_pkg::CfgNodeId:    r_node_id    <= i_cfg_data[3:0];
                cnre_pkg::CfgNodeCount: r_node_count <= i_cfg_data[4:0];
                cnre_pkg::CfgTimeout:   r_timeout    <= i_cfg_data;
                cnre_pkg::CfgLimit:     r_limit      <= i_cfg_data[7:0];
                default:                r_limit      <= r_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.cmd             <= i_in.cmd;
            r_in.msg_term        <= i_in.msg_term;
            r_in.sender          <= i_in.sender;
            r_in.fault           <= i_in.fault;
            r_in.value_in        <= i_in.value_in;
            r_in.proposal_number <= i_in.proposal_number;
            r_in.decision_number <= i_in.decision_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.role  <= (cnre_pkg::NodeIdRst == 4'd0) ? cnre_pkg::ROLE_LEADER
                                                        : cnre_pkg::ROLE_FOLLOWER;
            r_st.term  <= '0;
            r_st.votes <= '0;
            r_st.resp  <= '0;
            r_st.open  <= 1'b0;
            r_st.acks  <= '0;
            r_st.seen  <= '0;
            r_st.props <= '0;
            r_st.decs  <= '0;
            r_st.pend  <= '0;
            r_st.ticks <= cnre_pkg::TimeoutRst;
        end else if (load) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_idx     <= '0;
            r_last    <= '0;
        end else if (load) begin
            r_out_vld <= 1'b1;
            r_idx     <= '0;
            r_last    <= n_last;
        end else if (out_take) begin
            if (r_idx == r_last) begin
                r_out_vld <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_items  <= n_items;
            r_role_o <= role_code(n_st.role);
            r_done_o <= n_done;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.kind          = r_items[r_idx].kind;
    assign o_out.dest          = r_items[r_idx].dest;
    assign o_out.broadcast     = r_items[r_idx].bcast;
    assign o_out.out_term      = r_items[r_idx].term;
    assign o_out.out_value     = r_items[r_idx].value;
    assign o_out.out_proposals = r_items[r_idx].props;
    assign o_out.role          = r_role_o;
    assign o_out.decisions     = r_items[r_idx].decs;
    assign o_out.done_res      = r_done_o;
    assign o_out.last          = (r_idx == r_last);

    // a stalled bank keeps its position
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_out_vld && !o_out.ready, r_out_vld && (r_idx == $past(r_idx)), "result bank moved while stalled")

    // final transaction taken with nothing waiting empties the bank
    `ASSERT_NEXT(a_drain, i_clk, i_rst_n, out_take && (r_idx == r_last) && !r_in_vld, !r_out_vld, "result bank not emptied after final transaction")

    // an open proposal belongs to a leader only
    `ASSERT_NOW(a_open_leader, i_clk, i_rst_n, r_st.open, r_st.role == cnre_pkg::ROLE_LEADER, "proposal open outside leader role")

    // granted acks never exceed acks seen
    `ASSERT_NOW(a_ack_tally, i_clk, i_rst_n, 1'b1, r_st.acks <= r_st.seen, "ack tally above acks seen")

endmodule

/* tb/tb_consensus_node_role_engine.sv */
`timescale 1ns / 100ps

module tb_consensus_node_role_engine;

    localparam int WatchdogLimit = 3000;
    localparam int HoldCycles = 300;
    localparam int DrainCycles = 20;

    typedef struct packed {
        cnre_pkg::t_kind kind;
        logic [3:0]  dest;
        logic        bcast;
        logic [31:0] term;
        logic [31:0] value;
        logic [7:0]  props;
        logic [1:0]  role;
        logic [7:0]  decs;
        logic        done;
        logic        last;
    } t_node_result;

    class t_role_engine_scoreboard;
        logic [3:0]  cfg_id;
        logic [4:0]  cfg_count;
        logic [15:0] cfg_timeout;
        logic [7:0]  cfg_limit;
        logic [1:0]  role;
        logic [31:0] term;
        logic [4:0]  voted_for;
        logic [4:0]  votes;
        logic [4:0]  responses;
        logic        proposal_open;
        logic [4:0]  ack_tally;
        logic [4:0]  acks_seen;
        logic [7:0]  proposals;
        logic [7:0]  decisions;
        logic [31:0] pending_value;
        logic [15:0] ticks_left;
        t_node_result event_items[$];
        t_node_result expected_results[$];
        int errors;

        function new();
            errors = 0;
            cfg_id = cnre_pkg::NodeIdRst;
            cfg_count = cnre_pkg::NodeCountRst;
            cfg_timeout = cnre_pkg::TimeoutRst;
            cfg_limit = cnre_pkg::LimitRst;
            role = (cfg_id == 4'd0) ? cnre_pkg::RoleCodeLeader : cnre_pkg::RoleCodeFollower;
            term = '0;
            voted_for = 5'd16;
            votes = '0;
            responses = '0;
            proposal_open = 1'b0;
            ack_tally = '0;
            acks_seen = '0;
            proposals = '0;
            decisions = '0;
            pending_value = '0;
            ticks_left = cnre_pkg::TimeoutRst;
        endfunction

        function void set_cfg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                cnre_pkg::CfgNodeId:    cfg_id = data[3:0];
                cnre_pkg::CfgNodeCount: cfg_count = data[4:0];
                cnre_pkg::CfgTimeout:   cfg_timeout = data;
                default:                cfg_limit = data[7:0];
            endcase
        endfunction

        function int unsigned group_size();
            return (cfg_count > cnre_pkg::MaxNodes) ? cnre_pkg::MaxNodes : int'(cfg_count);
        endfunction

        function logic [4:0] inc5(logic [4:0] x);
            return (x == 5'd31) ? x : x + 5'd1;
        endfunction

        function void emit(cnre_pkg::t_kind k, logic [3:0] dest, logic bcast,
                           logic [31:0] t, logic [31:0] v, logic [7:0] p);
            t_node_result r;
            if (event_items.size() >= cnre_pkg::MaxItems) return;
            r = '0;
            r.kind = k;
            r.dest = dest;
            r.bcast = bcast;
            r.term = t;
            r.value = v;
            r.props = p;
            r.decs = decisions;
            event_items.push_back(r);
        endfunction

        function void close_vote();
            if (role != cnre_pkg::RoleCodeCandidate || int'(responses) < group_size()) return;
            if (int'(votes) > group_size() / 2) begin
                role = cnre_pkg::RoleCodeLeader;
                emit(cnre_pkg::KIND_WON, cfg_id, 1'b0, term, '0, '0);
            end else begin
                role = cnre_pkg::RoleCodeFollower;
            end
            ticks_left = cfg_timeout;
        endfunction

        function void check_quorum();
            if (!proposal_open) return;
            if (int'(ack_tally) > group_size() / 2) begin
                decisions = (decisions == 8'hFF) ? decisions : decisions + 8'd1;
                proposal_open = 1'b0;
                emit(cnre_pkg::KIND_COMMIT, cfg_id, 1'b0, term, pending_value, '0);
            end else if (int'(acks_seen) >= group_size()) begin
                proposal_open = 1'b0;
                emit(cnre_pkg::KIND_NO_QUORUM, cfg_id, 1'b0, term, pending_value, '0);
            end
        endfunction

        function void note_input(cnre_pkg::t_in_item it);
            logic [31:0] old_term;
            event_items.delete();
            if (decisions < cfg_limit) begin
                case (it.cmd)
                    cnre_pkg::CMD_TICK: begin
                        if (role == cnre_pkg::RoleCodeLeader) begin
                            if (!proposal_open) begin
                                pending_value = cnre_pkg::BaseValue + 32'(proposals);
                                proposals = (proposals == 8'hFF) ? proposals
                                                                 : proposals + 8'd1;
                                proposal_open = 1'b1;
                                ack_tally = 5'd1;
                                acks_seen = 5'd1;
                                emit(cnre_pkg::KIND_PROPOSAL, cfg_id, 1'b1, term,
                                     pending_value, proposals);
                            end
                            check_quorum();
                            if (it.fault) begin
                                role = cnre_pkg::RoleCodeFollower;
                                ticks_left = cfg_timeout;
                            end else begin
                                emit(cnre_pkg::KIND_HEARTBEAT, cfg_id, 1'b1, term, '0, '0);
                            end
                        end else begin
                            if (ticks_left != 16'd0) ticks_left = ticks_left - 16'd1;
                            if (ticks_left == 16'd0) begin
                                role = cnre_pkg::RoleCodeCandidate;
                                term = term + 32'd1;
                                votes = 5'd1;
                                responses = 5'd1;
                                voted_for = {1'b0, cfg_id};
                                ticks_left = cfg_timeout;
                                emit(cnre_pkg::KIND_VOTE_REQ, cfg_id, 1'b1, term, '0, '0);
                                close_vote();
                            end
                        end
                    end
                    cnre_pkg::CMD_VOTE_REQ: begin
                        old_term = term;
                        if (it.msg_term > term) begin
                            voted_for = {1'b0, it.sender};
                            role = cnre_pkg::RoleCodeFollower;
                            term = it.msg_term;
                            ticks_left = cfg_timeout;
                        end
                        emit(cnre_pkg::KIND_VOTE_RESP, it.sender, 1'b0, old_term, '0, '0);
                    end
                    cnre_pkg::CMD_HEARTBEAT: begin
                        if (it.msg_term >= term) begin
                            term = it.msg_term;
                            role = cnre_pkg::RoleCodeFollower;
                            voted_for = 5'd16;
                            ticks_left = cfg_timeout;
                        end
                    end
                    cnre_pkg::CMD_VOTE_RESP: begin
                        if (role == cnre_pkg::RoleCodeCandidate) begin
                            if (it.msg_term < term) begin
                                votes = inc5(votes);
                            end else if (it.msg_term > term) begin
                                term = it.msg_term;
                                role = cnre_pkg::RoleCodeFollower;
                                ticks_left = cfg_timeout;
                            end
                            responses = inc5(responses);
                            close_vote();
                        end
                    end
                    cnre_pkg::CMD_PROPOSAL: begin
                        if (role == cnre_pkg::RoleCodeFollower) begin
                            if (it.fault)
                                emit(cnre_pkg::KIND_FAILED_ACK, it.sender, 1'b0, term,
                                     cnre_pkg::FailedAck, '0);
                            else
                                emit(cnre_pkg::KIND_ACK, it.sender, 1'b0, term,
                                     it.value_in, '0);
                            proposals = it.proposal_number;
                            decisions = it.decision_number;
                        end
                    end
                    cnre_pkg::CMD_ACK: begin
                        if (role == cnre_pkg::RoleCodeLeader && proposal_open) begin
                            if (it.fault) begin
                                acks_seen = inc5(acks_seen);
                                check_quorum();
                            end else if (it.value_in == pending_value) begin
                                ack_tally = inc5(ack_tally);
                                acks_seen = inc5(acks_seen);
                                check_quorum();
                            end
                        end
                    end
                    default: ;
                endcase
                if (role == cnre_pkg::RoleCodeFollower) begin
                    proposal_open = 1'b0;
                    ack_tally = '0;
                    acks_seen = '0;
                end
            end
            if (event_items.size() >= cnre_pkg::MaxItems) void'(event_items.pop_back());
            emit(cnre_pkg::KIND_STATUS, cfg_id, 1'b0, term, pending_value, proposals);
            foreach (event_items[k]) begin
                event_items[k].role = role;
                event_items[k].done = (decisions >= cfg_limit);
                event_items[k].last = (k == event_items.size() - 1);
                expected_results.push_back(event_items[k]);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] %s", $time, msg);
        endtask

        task compare(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s mismatch: got %0h, expected %0h", field, got, want));
        endtask

        task check_result(t_node_result got);
            t_node_result want;
            if (expected_results.size() == 0) begin
                report($sformatf("result with nothing expected, kind %0d", got.kind));
                return;
            end
            want = expected_results.pop_front();
            compare("kind", 32'(got.kind), 32'(want.kind));
            compare("dest", 32'(got.dest), 32'(want.dest));
            compare("broadcast", 32'(got.bcast), 32'(want.bcast));
            compare("out_term", got.term, want.term);
            compare("out_value", got.value, want.value);
            compare("out_proposals", 32'(got.props), 32'(want.props));
            compare("role", 32'(got.role), 32'(want.role));
            compare("decisions", 32'(got.decs), 32'(want.decs));
            compare("done_res", 32'(got.done), 32'(want.done));
            compare("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    cnre_in_if  in_if();
    cnre_out_if out_if();

    t_role_engine_scoreboard sb;
    t_node_result seen_result;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    bit hold_pending = 1'b0;
    int quiet_cycles = 0;

    consensus_node_role_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen_result.kind = cnre_pkg::t_kind'(out_if.kind);
            seen_result.dest = out_if.dest;
            seen_result.bcast = out_if.broadcast;
            seen_result.term = out_if.out_term;
            seen_result.value = out_if.out_value;
            seen_result.props = out_if.out_proposals;
            seen_result.role = out_if.role;
            seen_result.decs = out_if.decisions;
            seen_result.done = out_if.done_res;
            seen_result.last = out_if.last;
            sb.check_result(seen_result);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic cnre_pkg::t_in_item event_item(logic [2:0] cmd, logic [31:0] msg_term,
                                                      logic [3:0] sender, logic fault,
                                                      logic [31:0] value, logic [7:0] pn,
                                                      logic [7:0] dn);
        cnre_pkg::t_in_item it;
        it.cmd = cmd;
        it.msg_term = msg_term;
        it.sender = sender;
        it.fault = fault;
        it.value_in = value;
        it.proposal_number = pn;
        it.decision_number = dn;
        return it;
    endfunction

    // mostly well-formed events for the current role, some noise
    function automatic cnre_pkg::t_in_item make_event();
        cnre_pkg::t_in_item it;
        int unsigned pick;
        pick = $urandom_range(99);
        it.cmd = 3'($urandom_range(5));
        it.msg_term = $urandom();
        it.sender = 4'($urandom());
        it.fault = ($urandom_range(7) == 0);
        it.value_in = $urandom();
        it.proposal_number = 8'($urandom());
        it.decision_number = ($urandom_range(9) == 0) ? 8'($urandom_range(252))
                                                       : 8'($urandom_range(15));
        if (pick < 8) begin
            it.cmd = 3'($urandom());
            it.fault = 1'($urandom());
        end else if (sb.cfg_limit >= 8 && int'(sb.decisions) + 2 >= int'(sb.cfg_limit)) begin
            // steer back to a follower with a low decision count
            case (sb.role)
                cnre_pkg::RoleCodeLeader: begin
                    it.cmd = cnre_pkg::CMD_TICK;
                    it.fault = 1'b1;
                end
                cnre_pkg::RoleCodeFollower: begin
                    it.cmd = cnre_pkg::CMD_PROPOSAL;
                    it.decision_number = 8'($urandom_range(15));
                end
                default: begin
                    it.cmd = cnre_pkg::CMD_HEARTBEAT;
                    it.msg_term = sb.term;
                end
            endcase
        end else if (sb.role == cnre_pkg::RoleCodeLeader) begin
            if (pick < 50) begin
                it.cmd = cnre_pkg::CMD_TICK;
                it.fault = ($urandom_range(11) == 0);
            end else begin
                it.cmd = cnre_pkg::CMD_ACK;
                it.fault = ($urandom_range(4) == 0);
                if (pick < 92) it.value_in = sb.pending_value;
            end
        end else if (sb.role == cnre_pkg::RoleCodeFollower) begin
            if (pick < 45) begin
                it.cmd = cnre_pkg::CMD_TICK;
            end else if (pick < 60) begin
                it.cmd = cnre_pkg::CMD_HEARTBEAT;
                it.msg_term = sb.term + 32'($urandom_range(2));
            end else if (pick < 85) begin
                it.cmd = cnre_pkg::CMD_PROPOSAL;
            end else begin
                it.cmd = cnre_pkg::CMD_VOTE_REQ;
                it.msg_term = sb.term + 32'($urandom_range(2)) - 32'd1;
            end
        end else begin
            if (pick < 75) begin
                it.cmd = cnre_pkg::CMD_VOTE_RESP;
                it.msg_term = sb.term - 32'($urandom_range(3));
            end else if (pick < 78) begin
                it.cmd = cnre_pkg::CMD_VOTE_RESP;
                it.msg_term = sb.term + 32'($urandom_range(3, 1));
            end else begin
                it.cmd = cnre_pkg::CMD_TICK;
            end
        end
        return it;
    endfunction

    task automatic send_event(input cnre_pkg::t_in_item it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd <= it.cmd;
        in_if.msg_term <= it.msg_term;
        in_if.sender <= it.sender;
        in_if.fault <= it.fault;
        in_if.value_in <= it.value_in;
        in_if.proposal_number <= it.proposal_number;
        in_if.decision_number <= it.decision_number;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_input(it);
    endtask

    task automatic wait_drained();
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_cfg(idx, data);
    endtask

    task automatic configure(input logic [3:0] id, input logic [4:0] count,
                             input logic [15:0] timeout, input logic [7:0] limit);
        write_reg(cnre_pkg::CfgNodeId, 16'(id));
        write_reg(cnre_pkg::CfgNodeCount, 16'(count));
        write_reg(cnre_pkg::CfgTimeout, timeout);
        write_reg(cnre_pkg::CfgLimit, 16'(limit));
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int n, input logic [3:0] id, input logic [4:0] count,
                             input logic [15:0] timeout, input logic [7:0] limit,
                             input int send_pct, input int stall_pct, input bit hold);
        wait_drained();
        configure(id, count, timeout, limit);
        send_idle_pct = send_pct;
        sink_stall_pct = stall_pct;
        if (hold) hold_pending = 1'b1;
        repeat (n) send_event(make_event());
        in_if.valid <= 1'b0;
    endtask

    task automatic directed_events();
        // leader round trips: commit, failed and foreign acks, no quorum, step down
        send_event(event_item(cnre_pkg::CMD_TICK, '0, 4'd0, 1'b0, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_ACK, '0, 4'd1, 1'b0, sb.pending_value, '0, '0));
        send_event(event_item(cnre_pkg::CMD_TICK, '0, 4'd0, 1'b0, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_ACK, '0, 4'd2, 1'b1, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_ACK, '0, 4'd1, 1'b0, 32'hFFFF_FFFF, '0, '0));
        send_event(event_item(cnre_pkg::CMD_ACK, '0, 4'd2, 1'b1, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_PROPOSAL, '1, 4'd15, 1'b1, '1, 8'hFF, 8'hFF));
        send_event(event_item(cnre_pkg::CMD_TICK, '0, 4'd0, 1'b1, '0, '0, '0));
        // follower side
        send_event(event_item(cnre_pkg::CMD_PROPOSAL, '0, 4'd0, 1'b1, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_PROPOSAL, '0, 4'd15, 1'b0, 32'hFFFF_FFFF,
                              8'hFF, '0));
        send_event(event_item(cnre_pkg::CMD_VOTE_REQ, '0, 4'd5, 1'b0, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_VOTE_REQ, 32'hFFFF_FFFF, 4'd15, 1'b0, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_HEARTBEAT, 32'd5, 4'd1, 1'b0, '0, '0, '0));
        send_event(event_item(3'd6, '0, 4'd0, 1'b0, '0, '0, '0));
        send_event(event_item(3'd7, '1, 4'd15, 1'b1, '1, '1, '0));
        in_if.valid <= 1'b0;
        wait_drained();
        configure(4'd0, 5'd3, 16'd1, 8'd10);
        // election with term wrap, a lost vote, a won election, step downs
        send_event(event_item(cnre_pkg::CMD_HEARTBEAT, 32'hFFFF_FFFF, 4'd2, 1'b0, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_TICK, '0, 4'd0, 1'b0, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_VOTE_RESP, '0, 4'd1, 1'b0, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_TICK, '0, 4'd0, 1'b0, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_VOTE_RESP, '0, 4'd1, 1'b0, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_VOTE_RESP, '0, 4'd2, 1'b0, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_TICK, '0, 4'd0, 1'b0, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_VOTE_REQ, 32'd9, 4'd3, 1'b0, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_TICK, '0, 4'd0, 1'b0, '0, '0, '0));
        send_event(event_item(cnre_pkg::CMD_VOTE_RESP, 32'd20, 4'd4, 1'b0, '0, '0, '0));
        in_if.valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= cnre_pkg::CfgNodeId;
        i_cfg_data <= '0;
        in_if.valid <= 1'b0;
        in_if.cmd <= cnre_pkg::CMD_TICK;
        in_if.msg_term <= '0;
        in_if.sender <= '0;
        in_if.fault <= 1'b0;
        in_if.value_in <= '0;
        in_if.proposal_number <= '0;
        in_if.decision_number <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_events();
        run_phase(110, 4'd0, 5'd3, 16'd4, 8'd255, 0, 0, 1'b0);
        run_phase(100, 4'd15, 5'd16, 16'd2, 8'd255, 61, 0, 1'b0);
        run_phase(100, 4'd7, 5'd1, 16'd3, 8'd255, 0, 61, 1'b0);
        run_phase(100, 4'd3, 5'd5, 16'd5, 8'd255, 12, 12, 1'b0);
        run_phase(60, 4'd1, 5'd2, 16'd65535, 8'd255, 0, 0, 1'b1);
        // lowest limit: the node reaches done and ignores what follows
        run_phase(20, 4'd0, 5'd1, 16'd1, 8'd1, 12, 12, 1'b0);

        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* consensus_node_role_engine.f */
+incdir+src
src/cnre_pkg.sv
src/cnre_in_if.sv
src/cnre_out_if.sv
src/consensus_node_role_engine.sv
tb/tb_consensus_node_role_engine.sv
